/* rtl/core/mta_pkg.sv */
// ----------------------------------------------------------------------------
// mta_pkg
// Shared types, constants and helpers for the tiled texel address block.
// ----------------------------------------------------------------------------
package mta_pkg;

    localparam int unsigned DefMaxLevels = 15;
    localparam int unsigned DefMaxDim    = 16384;

    localparam int unsigned CoordW  = 14;
    localparam int unsigned LevelW  = 4;
    localparam int unsigned DimW    = 15;
    localparam int unsigned OffsetW = 31;
    localparam int unsigned BlkW    = 8;
    localparam int unsigned SwzW    = 16;
    localparam int unsigned TailMax = 12;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CFG   = 2'd1,
        ST_BAD_LEVEL = 2'd2,
        ST_BAD_COORD = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        REG_BASE_WIDTH  = 2'd0,
        REG_BASE_HEIGHT = 2'd1,
        REG_LEVEL_COUNT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic              cfg_ok;
        logic              has_tail;
        logic [LevelW-1:0] first_tail;
        logic [DimW-1:0]   width;
        logic [DimW-1:0]   height;
        logic [LevelW-1:0] count;
    } t_cfg_info;

    function automatic logic [SwzW-1:0] swizzle(input logic [6:0] x, input logic [6:0] y);
        logic [SwzW-1:0] s;
        s = '0;
        s[6:4]   = y[2:0];
        s[11:8]  = y[6:3];
        s[12]    = y[3];
        s[14]    = y[6];
        s[3:2]   = x[1:0];
        s[9:7]   = s[9:7] ^ x[4:2];
        s[10]    = s[10] ^ x[6];
        s[11]    = s[11] ^ x[5];
        s[13]    = s[13] ^ x[4];
        s[15]    = s[15] ^ x[6];
        return s;
    endfunction

    function automatic logic [6:0] tail_dx(input logic [3:0] t);
        case (t)
            4'd0:    return 7'd64;
            4'd2:    return 7'd32;
            4'd4:    return 7'd16;
            4'd5:    return 7'd8;
            4'd8:    return 7'd8;
            4'd9:    return 7'd8;
            default: return 7'd0;
        endcase
    endfunction

    function automatic logic [6:0] tail_dy(input logic [3:0] t);
        case (t)
            4'd1:    return 7'd64;
            4'd3:    return 7'd32;
            4'd5:    return 7'd16;
            4'd6:    return 7'd24;
            4'd7:    return 7'd16;
            4'd8:    return 7'd8;
            4'd10:   return 7'd8;
            default: return 7'd0;
        endcase
    endfunction

endpackage

/* rtl/core/mta_cfg.sv */
// ----------------------------------------------------------------------------
// mta_cfg
// Configuration registers and the chain layout derived from them.
// ----------------------------------------------------------------------------
module mta_cfg #(
    parameter int unsigned MAX_LEVELS = mta_pkg::DefMaxLevels,
    parameter int unsigned MAX_DIM    = mta_pkg::DefMaxDim
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [1:0]                             i_cfg_idx,
    input  logic [mta_pkg::DimW-1:0]               i_cfg_data,
    output mta_pkg::t_cfg_info                     o_info,
    output logic [MAX_LEVELS-1:0][mta_pkg::BlkW-1:0] o_bw,
    output logic [MAX_LEVELS-1:0][mta_pkg::BlkW-1:0] o_bh
);
    import mta_pkg::*;

    logic [DimW-1:0]   r_width, r_height;
    logic [LevelW-1:0] r_count;
    logic [DimW-1:0]   w_dmax;
    logic [LevelW-1:0] w_ft;
    logic              w_fit;
    logic [22:0]       w_wsum, w_hsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DimW'(1);
            r_height <= DimW'(1);
            r_count  <= LevelW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BASE_WIDTH:  r_width  <= i_cfg_data;
                REG_BASE_HEIGHT: r_height <= i_cfg_data;
                REG_LEVEL_COUNT: r_count  <= i_cfg_data[LevelW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_dmax = (r_width > r_height) ? r_width : r_height;
        w_ft   = r_count;
        w_fit  = 1'b0;
        w_wsum = '0;
        w_hsum = '0;
        for (int m = MAX_LEVELS - 1; m >= 0; m--) begin
            w_fit = (22'(r_width) <= (22'(64) << m)) && (22'(r_height) <= (22'(128) << m));
            if ((4'(m) < r_count) && (r_count > 4'd1) && w_fit &&
                ((r_count - 4'(m)) <= 4'(TailMax)))
                w_ft = 4'(m);
        end
        for (int m = 0; m < MAX_LEVELS; m++) begin
            w_wsum  = (23'(r_width) + (23'(1) << (m + 7)) - 23'd1) >> (m + 7);
            w_hsum  = (23'(r_height) + (23'(1) << (m + 7)) - 23'd1) >> (m + 7);
            o_bw[m] = w_wsum[BlkW-1:0];
            o_bh[m] = w_hsum[BlkW-1:0];
        end
    end

    assign o_info.cfg_ok = (r_width != '0) && (r_height != '0) &&
                           (32'(r_width) <= MAX_DIM) && (32'(r_height) <= MAX_DIM) &&
                           (r_count != '0) && (32'(r_count) <= MAX_LEVELS) &&
                           ((w_dmax >> (r_count - 4'd1)) != '0);
    assign o_info.has_tail   = (w_ft < r_count);
    assign o_info.first_tail = w_ft;
    assign o_info.width      = r_width;
    assign o_info.height     = r_height;
    assign o_info.count      = r_count;

endmodule

/* rtl/core/mip_tiled_texel_address_top.sv */
// ----------------------------------------------------------------------------
// mip_tiled_texel_address_top
// Byte offset of a 32-bit texel in a 64 KiB-block tiled, swizzled mip chain.
// ----------------------------------------------------------------------------
// Four register stages; one request in per cycle unless the output stalls.
// The first stage registers the request; the second holds the checks and one
// block product per level lane, the third the lane sums in groups of four and
// the block index, the fourth, the output register, the assembled offset. A
// stalled output holds the whole pipeline. Configuration must be written only
// while no request is in flight; the block itself does not enforce this.
module mip_tiled_texel_address_top #(
    parameter int unsigned MAX_LEVELS = mta_pkg::DefMaxLevels,
    parameter int unsigned MAX_DIM    = mta_pkg::DefMaxDim
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_idx,
    input  logic [mta_pkg::DimW-1:0] i_cfg_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [31:0]              s_axis_tdata,  // texel_x[13:0], texel_y[27:14], mip_level[31:28]
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [31:0]              m_axis_tdata,  // byte_offset[30:0], zero pad[31]
    output logic [1:0]               m_axis_tuser   // status[1:0]
);
    import mta_pkg::*;

    localparam int unsigned NGroups = (MAX_LEVELS + 3) / 4;

    t_cfg_info                          w_cfg;
    logic [MAX_LEVELS-1:0][BlkW-1:0]    w_bw, w_bh;
    logic                               w_en;

    // stage a: captured request
    logic                  r_va;
    logic [CoordW-1:0]     r_xa, r_ya;
    logic [LevelW-1:0]     r_la;
    // stage b
    logic                  r_vb, r_tailb;
    t_status               r_stb;
    logic [SwzW-1:0]       r_swzb;
    logic [6:0]            r_yhb, r_xhb;
    logic [BlkW-1:0]       r_pitchb;
    logic [MAX_LEVELS-1:0][15:0] r_prodb, n_prod;
    // stage c
    logic                  r_vc, r_tailc;
    t_status               r_stc;
    logic [SwzW-1:0]       r_swzc;
    logic [15:0]           r_blkc;
    logic [NGroups-1:0][17:0] r_grpc, n_grp;
    // stage d
    logic                  r_vd;
    t_status               r_std;
    logic [OffsetW-1:0]    r_offd, n_off;

    t_status               n_st;
    logic [DimW-1:0]       w_wf, w_hf;
    logic [3:0]            w_t;
    logic [SwzW-1:0]       n_swz;
    logic [21:0]           w_sum;
    logic [22:0]           w_blocks;

    mta_cfg #(.MAX_LEVELS(MAX_LEVELS), .MAX_DIM(MAX_DIM)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_info     (w_cfg),
        .o_bw       (w_bw),
        .o_bh       (w_bh)
    );

    assign w_en          = !r_vd || m_axis_tready;
    assign s_axis_tready = w_en;

    // stage a -> b
    always_comb begin
        w_wf = w_cfg.width >> r_la;
        w_hf = w_cfg.height >> r_la;
        if (w_wf == '0) w_wf = DimW'(1);
        if (w_hf == '0) w_hf = DimW'(1);
        if (!w_cfg.cfg_ok)                                      n_st = ST_BAD_CFG;
        else if (r_la >= w_cfg.count)                           n_st = ST_BAD_LEVEL;
        else if ((DimW'(r_xa) >= w_wf) || (DimW'(r_ya) >= w_hf)) n_st = ST_BAD_COORD;
        else                                                    n_st = ST_OK;
        w_t = r_la - w_cfg.first_tail;
        if (w_t > 4'(TailMax - 1)) w_t = 4'(TailMax - 1);
        if (r_la >= w_cfg.first_tail)
            n_swz = swizzle(r_xa[6:0] + tail_dx(w_t), r_ya[6:0] + tail_dy(w_t));
        else
            n_swz = swizzle(r_xa[6:0], r_ya[6:0]);
        for (int m = 0; m < MAX_LEVELS; m++) begin
            if ((4'(m) > r_la) && (4'(m) < w_cfg.first_tail))
                n_prod[m] = w_bw[m] * w_bh[m];
            else
                n_prod[m] = '0;
        end
    end

    // stage b -> c
    always_comb begin
        for (int g = 0; g < NGroups; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < 4; k++) begin
                if (g * 4 + k < MAX_LEVELS)
                    n_grp[g] = n_grp[g] + 18'(r_prodb[g * 4 + k]);
            end
        end
    end

    // stage c -> d
    always_comb begin
        w_sum = '0;
        for (int g = 0; g < NGroups; g++)
            w_sum = w_sum + 22'(r_grpc[g]);
        w_blocks = 23'(w_sum) + 23'(r_blkc) + 23'(w_cfg.has_tail);
        if (r_stc != ST_OK)  n_off = '0;
        else if (r_tailc)    n_off = OffsetW'(r_swzc);
        else                 n_off = {w_blocks[OffsetW-SwzW-1:0], r_swzc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else if (w_en) begin
            r_va <= s_axis_tvalid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xa     <= s_axis_tdata[13:0];
            r_ya     <= s_axis_tdata[27:14];
            r_la     <= s_axis_tdata[31:28];
            r_stb    <= n_st;
            r_tailb  <= (r_la >= w_cfg.first_tail);
            r_swzb   <= n_swz;
            r_xhb    <= r_xa[13:7];
            r_yhb    <= r_ya[13:7];
            r_pitchb <= w_bw[r_la];
            r_prodb  <= n_prod;
            r_stc    <= r_stb;
            r_tailc  <= r_tailb;
            r_swzc   <= r_swzb;
            r_blkc   <= 16'(r_yhb) * 16'(r_pitchb) + 16'(r_xhb);
            r_grpc   <= n_grp;
            r_std    <= r_stc;
            r_offd   <= n_off;
        end
    end

    assign m_axis_tvalid = r_vd;
    assign m_axis_tdata  = {1'b0, r_offd};
    assign m_axis_tuser  = r_std;

`ifndef SYNTH
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == '0))
        else $error("nonzero offset on error status");
    a_bad_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !w_cfg.cfg_ok) |-> (m_axis_tuser == ST_BAD_CFG))
        else $error("bad configuration not reported");
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vc && w_en) |=> m_axis_tvalid)
        else $error("request lost at output stage");
`endif

endmodule
